/* rtl/core/sfcs_pkg.sv */
// Package for the SPI flash command sequencer: command, phase and job codes,
// flash opcodes and the structs passed between front, queue and back.
// No dependencies.
package sfcs_pkg;

  localparam int DEFAULT_PAGE_BYTES   = 256;
  localparam int DEFAULT_ADDRESS_BITS = 24;
  localparam int DEFAULT_QUEUE_DEPTH  = 4;

  localparam int MAX_RESULTS = 9;
  localparam int STEP_BITS   = $clog2(MAX_RESULTS);

  localparam logic [7:0] BUSY_MASK_RESET = 8'h01;

  localparam logic [7:0] OPC_POWER_DOWN   = 8'hB9;
  localparam logic [7:0] OPC_FAST_READ    = 8'h0B;
  localparam logic [7:0] OPC_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] OPC_PAGE_PROGRAM = 8'h02;
  localparam logic [7:0] OPC_READ_STATUS  = 8'h05;
  localparam logic [7:0] OPC_ERASE_4K     = 8'h20;
  localparam logic [7:0] OPC_WRITE_STATUS = 8'h01;

  typedef enum logic [3:0] {
    CMD_POWER_DOWN  = 4'd0,
    CMD_READ_START  = 4'd1,
    CMD_READ_BYTE   = 4'd2,
    CMD_WRITE_START = 4'd3,
    CMD_WRITE_BYTE  = 4'd4,
    CMD_ERASE_4K    = 4'd5,
    CMD_SET_STATUS  = 4'd6,
    CMD_POLL_REPLY  = 4'd7,
    CMD_READ_STATUS = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_READ        = 3'd1,
    PH_WRITE       = 3'd2,
    PH_POLL_END    = 3'd3,
    PH_POLL_RESUME = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    OP_ERROR,
    OP_POWER_DOWN,
    OP_READ_START,
    OP_READ_BYTE,
    OP_READ_LAST,
    OP_WRITE_START,
    OP_WRITE_BYTE,
    OP_WRITE_POLL,
    OP_ERASE,
    OP_SET_STATUS,
    OP_READ_STATUS,
    OP_POLL_BUSY,
    OP_POLL_DONE,
    OP_POLL_RESUME
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [23:0] addr;
    logic [7:0]  data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] mosi;
    logic       reply;
    logic       error;
  } result_t;

endpackage

/* rtl/core/sfcs_front.sv */
// Front end: accepts host commands, checks them against the phase, tracks
// the write address and busy mask, and pushes one job per command.
// Depends on sfcs_pkg.
module sfcs_front
  import sfcs_pkg::*;
#(
  parameter int PAGE_BYTES   = DEFAULT_PAGE_BYTES,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_enable,
  input  logic [7:0]    cfg_write_data,
  input  logic          cmd_valid,
  input  logic [3:0]    cmd,
  input  logic [23:0]   address,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  queue_status_t status,
  output logic          push,
  output job_t          job
);

  localparam logic [23:0] ADDR_MASK = (ADDRESS_BITS >= 24) ? 24'hFFFFFF :
                                      24'((33'd1 << ADDRESS_BITS) - 33'd1);
  // PAGE_BYTES is a power of two
  localparam logic [23:0] PAGE_MASK = 24'(PAGE_BYTES - 1);

  phase_t      phase, phase_next;
  logic [23:0] next_address, next_address_next;
  logic [7:0]  busy_mask;
  logic [23:0] addr_in;
  logic [23:0] addr_inc;

  assign push     = cmd_valid && !status.full;
  assign addr_in  = address & ADDR_MASK;
  assign addr_inc = (next_address + 24'd1) & ADDR_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      next_address <= '0;
      busy_mask    <= BUSY_MASK_RESET;
    end else begin
      if (push) begin
        phase        <= phase_next;
        next_address <= next_address_next;
      end
      if (cfg_write_enable) begin
        busy_mask <= cfg_write_data;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    next_address_next = next_address;
    job.op            = OP_ERROR;
    job.addr          = addr_in;
    job.data          = data_byte;
    unique case (cmd)
      CMD_POWER_DOWN: begin
        if (phase == PH_IDLE) job.op = OP_POWER_DOWN;
      end
      CMD_READ_START: begin
        if (phase == PH_IDLE) begin
          job.op     = OP_READ_START;
          phase_next = PH_READ;
        end
      end
      CMD_READ_BYTE: begin
        if (phase == PH_READ) begin
          job.op = last_byte ? OP_READ_LAST : OP_READ_BYTE;
          if (last_byte) phase_next = PH_IDLE;
        end
      end
      CMD_WRITE_START: begin
        if (phase == PH_IDLE) begin
          job.op            = OP_WRITE_START;
          next_address_next = addr_in;
          phase_next        = PH_WRITE;
        end
      end
      CMD_WRITE_BYTE: begin
        if (phase == PH_WRITE) begin
          next_address_next = addr_inc;
          if (last_byte) begin
            job.op     = OP_WRITE_POLL;
            phase_next = PH_POLL_END;
          end else if ((addr_inc & PAGE_MASK) == 24'd0) begin
            job.op     = OP_WRITE_POLL;
            phase_next = PH_POLL_RESUME;
          end else begin
            job.op = OP_WRITE_BYTE;
          end
        end
      end
      CMD_ERASE_4K: begin
        if (phase == PH_IDLE) begin
          job.op     = OP_ERASE;
          phase_next = PH_POLL_END;
        end
      end
      CMD_SET_STATUS: begin
        if (phase == PH_IDLE) job.op = OP_SET_STATUS;
      end
      CMD_POLL_REPLY: begin
        if (phase == PH_POLL_END || phase == PH_POLL_RESUME) begin
          if ((data_byte & busy_mask) != 8'd0) begin
            job.op = OP_POLL_BUSY;
          end else if (phase == PH_POLL_RESUME) begin
            job.op     = OP_POLL_RESUME;
            job.addr   = next_address;
            phase_next = PH_WRITE;
          end else begin
            job.op     = OP_POLL_DONE;
            phase_next = PH_IDLE;
          end
        end
      end
      CMD_READ_STATUS: begin
        if (phase == PH_IDLE) job.op = OP_READ_STATUS;
      end
      default: begin
        job.op = OP_ERROR;
      end
    endcase
  end

  a_error_holds_phase: assert property (@(posedge clk) disable iff (rst)
    push && job.op == OP_ERROR |=> phase == $past(phase) &&
      next_address == $past(next_address))
    else $error("error job changed sequencer state");

endmodule

/* rtl/core/sfcs_queue.sv */
// Short job queue between the front end and the SPI word generator.
// Depends on sfcs_pkg.
module sfcs_queue
  import sfcs_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head,
  output queue_status_t status
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  job_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full) && !(pop && status.empty))
    else $error("job queue overflow or underflow");

endmodule

/* rtl/core/sfcs_back.sv */
// Back end: expands each queued job into its SPI words, one per cycle while
// res_stall is low, into a registered result stage.
// Depends on sfcs_pkg.
module sfcs_back
  import sfcs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  job_t          head,
  input  queue_status_t status,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_stall,
  output logic          kind,
  output logic [7:0]    mosi_byte,
  output logic          expect_reply,
  output logic          error,
  output logic          last_result
);

  localparam result_t W_REL = '{kind: 1'b1, mosi: 8'h00, reply: 1'b0, error: 1'b0};
  localparam result_t W_REP = '{kind: 1'b0, mosi: 8'h00, reply: 1'b1, error: 1'b0};
  localparam result_t W_ERR = '{kind: 1'b0, mosi: 8'h00, reply: 1'b0, error: 1'b1};

  logic [STEP_BITS-1:0] step;
  logic                 adv;
  logic                 at_last;
  result_t              word;

  function automatic result_t w_send(logic [7:0] b);
    result_t r;
    r      = '0;
    r.mosi = b;
    return r;
  endfunction

  function automatic logic [STEP_BITS-1:0] seq_last(op_t op);
    logic [STEP_BITS-1:0] n;
    unique case (op)
      OP_POWER_DOWN:  n = STEP_BITS'(1);
      OP_READ_START:  n = STEP_BITS'(4);
      OP_READ_LAST:   n = STEP_BITS'(1);
      OP_WRITE_START: n = STEP_BITS'(5);
      OP_WRITE_POLL:  n = STEP_BITS'(3);
      OP_ERASE:       n = STEP_BITS'(8);
      OP_SET_STATUS:  n = STEP_BITS'(4);
      OP_READ_STATUS: n = STEP_BITS'(2);
      OP_POLL_RESUME: n = STEP_BITS'(6);
      default:        n = '0;
    endcase
    return n;
  endfunction

  function automatic result_t seq_word(op_t op, logic [STEP_BITS-1:0] s,
                                       logic [23:0] a, logic [7:0] d);
    result_t r;
    r = '0;
    unique case (op)
      OP_ERROR:      r = W_ERR;
      OP_POWER_DOWN: r = (s == 0) ? w_send(OPC_POWER_DOWN) : W_REL;
      OP_READ_START: begin
        unique case (s)
          0:       r = w_send(OPC_FAST_READ);
          1:       r = w_send(a[23:16]);
          2:       r = w_send(a[15:8]);
          3:       r = w_send(a[7:0]);
          default: r = w_send(8'h00);
        endcase
      end
      OP_READ_BYTE:  r = W_REP;
      OP_READ_LAST:  r = (s == 0) ? W_REP : W_REL;
      OP_WRITE_START: begin
        unique case (s)
          0:       r = w_send(OPC_WRITE_ENABLE);
          1:       r = W_REL;
          2:       r = w_send(OPC_PAGE_PROGRAM);
          3:       r = w_send(a[23:16]);
          4:       r = w_send(a[15:8]);
          default: r = w_send(a[7:0]);
        endcase
      end
      OP_WRITE_BYTE: r = w_send(d);
      OP_WRITE_POLL: begin
        unique case (s)
          0:       r = w_send(d);
          1:       r = W_REL;
          2:       r = w_send(OPC_READ_STATUS);
          default: r = W_REP;
        endcase
      end
      OP_ERASE: begin
        unique case (s)
          0:       r = w_send(OPC_WRITE_ENABLE);
          1:       r = W_REL;
          2:       r = w_send(OPC_ERASE_4K);
          3:       r = w_send(a[23:16]);
          4:       r = w_send(a[15:8]);
          5:       r = w_send(a[7:0]);
          6:       r = W_REL;
          7:       r = w_send(OPC_READ_STATUS);
          default: r = W_REP;
        endcase
      end
      OP_SET_STATUS: begin
        unique case (s)
          0:       r = w_send(OPC_WRITE_ENABLE);
          1:       r = W_REL;
          2:       r = w_send(OPC_WRITE_STATUS);
          3:       r = w_send(d);
          default: r = W_REL;
        endcase
      end
      OP_READ_STATUS: begin
        unique case (s)
          0:       r = w_send(OPC_READ_STATUS);
          1:       r = W_REP;
          default: r = W_REL;
        endcase
      end
      OP_POLL_BUSY:  r = W_REP;
      OP_POLL_DONE:  r = W_REL;
      OP_POLL_RESUME: begin
        unique case (s)
          0:       r = W_REL;
          1:       r = w_send(OPC_WRITE_ENABLE);
          2:       r = W_REL;
          3:       r = w_send(OPC_PAGE_PROGRAM);
          4:       r = w_send(a[23:16]);
          5:       r = w_send(a[15:8]);
          default: r = w_send(a[7:0]);
        endcase
      end
      default: r = W_ERR;
    endcase
    return r;
  endfunction

  assign adv     = !res_valid || !res_stall;
  assign at_last = (step == seq_last(head.op));
  assign word    = seq_word(head.op, step, head.addr, head.data);
  assign pop     = adv && !status.empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      step      <= '0;
    end else if (adv) begin
      res_valid <= !status.empty;
      if (!status.empty) step <= at_last ? '0 : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !status.empty) begin
      kind         <= word.kind;
      mosi_byte    <= word.mosi;
      expect_reply <= word.reply;
      error        <= word.error;
      last_result  <= at_last;
    end
  end

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && error |-> last_result && !kind && !expect_reply)
    else $error("error word not a lone final result");

  a_release_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind |-> mosi_byte == 8'h00 && !expect_reply)
    else $error("release word carries data");

  a_step_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> step == '0)
    else $error("step counter not restarted after job");

endmodule

/* rtl/core/spi_flash_command_sequencer_core.sv */
// Top level of the SPI flash command sequencer: front end, job queue and
// SPI word generator. Depends on sfcs_pkg, sfcs_front, sfcs_queue, sfcs_back.
//
//   channel  direction  handshake               payload
//   command  in         cmd_valid / cmd_stall    cmd, address, data_byte, last_byte
//   result   out        res_valid / res_stall    kind, mosi_byte, expect_reply,
//                                                error, last_result
//   config   in         cfg_write_enable         cfg_write_data (busy_mask)
//
// One command is accepted per cycle while the job queue has room.
// The word generator emits one result per cycle while res_stall is low, and a
// command occupies it for all of its results: 1 to 9 (page program header: 6).
// Synchronous reset: busy_mask 0x01, phase idle, address 0, queue empty.
// res_stall holds the result register; the queue then fills and raises
// cmd_stall.
module spi_flash_command_sequencer_core
  import sfcs_pkg::*;
#(
  parameter int PAGE_BYTES   = DEFAULT_PAGE_BYTES,
  parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS,
  parameter int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [3:0]  cmd,
  input  logic [23:0] address,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [7:0]  mosi_byte,
  output logic        expect_reply,
  output logic        error,
  output logic        last_result
);

  queue_status_t status;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;

  assign cmd_stall = status.full;

  sfcs_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data  (cfg_write_data),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .address         (address),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .status          (status),
    .push            (push),
    .job             (push_job)
  );

  sfcs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .status  (status)
  );

  sfcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .status      (status),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .mosi_byte   (mosi_byte),
    .expect_reply(expect_reply),
    .error       (error),
    .last_result (last_result)
  );

endmodule

/* sim/tb.sv */
// Testbench for spi_flash_command_sequencer_core: drives flash commands and busy_mask
// writes, predicts every SPI word in a scoreboard class and checks each accepted result.
// Depends on sfcs_pkg and the sequencer RTL.
module tb;
  import sfcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BYTES = DEFAULT_PAGE_BYTES;
  localparam logic [23:0] ADDR_MASK = (DEFAULT_ADDRESS_BITS >= 24) ? 24'hFFFFFF :
                                      24'((1 << DEFAULT_ADDRESS_BITS) - 1);
  localparam logic [3:0] CMD_FIRST_UNKNOWN = 4'd9;
  localparam logic [3:0] CMD_LAST_UNKNOWN = 4'd15;

  typedef struct packed {
    logic       kind;
    logic [7:0] mosi;
    logic       reply;
    logic       err;
    logic       last;
  } spi_word_t;

  class spi_word_board;
    spi_word_t  pending_words[$];
    spi_word_t  step_words[$];
    logic [7:0] busy_mask;
    phase_t     phase;
    logic [23:0] next_addr;
    int         errors;

    function new();
      busy_mask = BUSY_MASK_RESET;
      phase = PH_IDLE;
      next_addr = 24'h000000;
      errors = 0;
    endfunction

    function void push_word(logic k, logic [7:0] mo, logic rp, logic er);
      step_words.push_back(spi_word_t'{k, mo, rp, er, 1'b0});
    endfunction

    function void send_byte(logic [7:0] b);
      push_word(1'b0, b, 1'b0, 1'b0);
    endfunction

    function void send_reply();
      push_word(1'b0, 8'h00, 1'b1, 1'b0);
    endfunction

    function void release_cs();
      push_word(1'b1, 8'h00, 1'b0, 1'b0);
    endfunction

    function void send_addr(logic [23:0] a);
      send_byte(a[23:16]);
      send_byte(a[15:8]);
      send_byte(a[7:0]);
    endfunction

    function void program_header(logic [23:0] a);
      send_byte(OPC_WRITE_ENABLE);
      release_cs();
      send_byte(OPC_PAGE_PROGRAM);
      send_addr(a);
    endfunction

    function void status_poll_start();
      release_cs();
      send_byte(OPC_READ_STATUS);
      send_reply();
    endfunction

    function void predict_words(logic [3:0] c, logic [23:0] a_in, logic [7:0] d, logic l);
      logic [23:0] a;
      logic ok;
      a = a_in & ADDR_MASK;
      step_words.delete();
      case (c)
        CMD_READ_BYTE:  ok = (phase == PH_READ);
        CMD_WRITE_BYTE: ok = (phase == PH_WRITE);
        CMD_POLL_REPLY: ok = (phase == PH_POLL_END || phase == PH_POLL_RESUME);
        CMD_POWER_DOWN, CMD_READ_START, CMD_WRITE_START, CMD_ERASE_4K, CMD_SET_STATUS,
        CMD_READ_STATUS: ok = (phase == PH_IDLE);
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        push_word(1'b0, 8'h00, 1'b0, 1'b1);
      end else begin
        case (c)
          CMD_POWER_DOWN: begin
            send_byte(OPC_POWER_DOWN);
            release_cs();
          end
          CMD_READ_START: begin
            send_byte(OPC_FAST_READ);
            send_addr(a);
            send_byte(8'h00);
            phase = PH_READ;
          end
          CMD_READ_BYTE: begin
            send_reply();
            if (l) begin
              release_cs();
              phase = PH_IDLE;
            end
          end
          CMD_WRITE_START: begin
            program_header(a);
            next_addr = a;
            phase = PH_WRITE;
          end
          CMD_WRITE_BYTE: begin
            send_byte(d);
            next_addr = (next_addr + 24'd1) & ADDR_MASK;
            if (l) begin
              status_poll_start();
              phase = PH_POLL_END;
            end else if (int'(next_addr) % PAGE_BYTES == 0) begin
              status_poll_start();
              phase = PH_POLL_RESUME;
            end
          end
          CMD_ERASE_4K: begin
            send_byte(OPC_WRITE_ENABLE);
            release_cs();
            send_byte(OPC_ERASE_4K);
            send_addr(a);
            status_poll_start();
            phase = PH_POLL_END;
          end
          CMD_SET_STATUS: begin
            send_byte(OPC_WRITE_ENABLE);
            release_cs();
            send_byte(OPC_WRITE_STATUS);
            send_byte(d);
            release_cs();
          end
          CMD_POLL_REPLY: begin
            if ((d & busy_mask) != 8'h00) begin
              send_reply();
            end else begin
              release_cs();
              if (phase == PH_POLL_RESUME) begin
                program_header(next_addr);
                phase = PH_WRITE;
              end else begin
                phase = PH_IDLE;
              end
            end
          end
          default: begin
            send_byte(OPC_READ_STATUS);
            send_reply();
            release_cs();
          end
        endcase
      end
      step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    function void compare_field(string label, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic k, logic [7:0] mo, logic rp, logic er, logic la);
      spi_word_t w;
      if (pending_words.size() == 0) begin
        $display("%0t: word with none expected, expected nothing actual kind %0d mosi %02h",
                 $time, k, mo);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      compare_field("kind", w.kind, k);
      compare_field("mosi_byte", w.mosi, mo);
      compare_field("expect_reply", w.reply, rp);
      compare_field("error", w.err, er);
      compare_field("last_result", w.last, la);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [7:0]  cfg_write_data = 8'h00;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [3:0]  cmd = 4'd0;
  logic [23:0] address = 24'h000000;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        kind;
  logic [7:0]  mosi_byte;
  logic        expect_reply;
  logic        error;
  logic        last_result;

  logic idle_on = 1'b0;
  int   stall_left = 0;
  int   items_sent = 0;
  spi_word_board board = new();

  spi_flash_command_sequencer_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .cmd_valid        (cmd_valid),
    .cmd_stall        (cmd_stall),
    .cmd              (cmd),
    .address          (address),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .kind             (kind),
    .mosi_byte        (mosi_byte),
    .expect_reply     (expect_reply),
    .error            (error),
    .last_result      (last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && !res_stall)
      board.check_word(kind, mosi_byte, expect_reply, error, last_result);
  end

  task automatic send_command(input logic [3:0] c, input logic [23:0] a, input logic [7:0] d,
                              input logic l);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    address <= a;
    data_byte <= d;
    last_byte <= l;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    board.predict_words(c, a, d, l);
    items_sent++;
  endtask

  task automatic wait_all_words();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (board.pending_words.size() != 0);
  endtask

  task automatic answer_polls();
    logic [7:0] d;
    int busy_count;
    busy_count = (board.busy_mask == 8'h00) ? 0 : $urandom_range(0, 3);
    repeat (busy_count) begin
      do d = 8'($urandom); while ((d & board.busy_mask) == 8'h00);
      send_command(CMD_POLL_REPLY, 24'($urandom), d, 1'($urandom));
    end
    d = 8'($urandom);
    send_command(CMD_POLL_REPLY, 24'($urandom), d & ~board.busy_mask, 1'($urandom));
  endtask

  task automatic recover_idle();
    while (board.phase != PH_IDLE) begin
      case (board.phase)
        PH_READ:  send_command(CMD_READ_BYTE, 24'($urandom), 8'($urandom), 1'b1);
        PH_WRITE: send_command(CMD_WRITE_BYTE, 24'($urandom), 8'($urandom), 1'b1);
        default:  answer_polls();
      endcase
    end
  endtask

  initial begin
    int r;
    int len;
    int start_items;
    logic [23:0] a;
    logic [7:0] m;
    logic [7:0] mask_plan[5];
    mask_plan = '{8'h00, 8'hFF, 8'h80, 8'h5A, BUSY_MASK_RESET};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(CMD_POWER_DOWN, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_READ_STATUS, 24'hFFFFFF, 8'hFF, 1'b1);
    send_command(CMD_SET_STATUS, 24'hFFFFFF, 8'hFF, 1'b1);
    send_command(CMD_READ_START, 24'hFFFFFF, 8'h00, 1'b0);
    send_command(CMD_READ_BYTE, 24'h000000, 8'hFF, 1'b0);
    send_command(CMD_WRITE_START, 24'h123456, 8'h00, 1'b0);
    send_command(CMD_READ_BYTE, 24'hFFFFFF, 8'h00, 1'b1);
    send_command(CMD_READ_BYTE, 24'h000000, 8'h00, 1'b1);
    send_command(CMD_WRITE_BYTE, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_POLL_REPLY, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_FIRST_UNKNOWN, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_LAST_UNKNOWN, 24'hFFFFFF, 8'hFF, 1'b1);
    send_command(CMD_WRITE_START, 24'h0000FE, 8'h00, 1'b0);
    send_command(CMD_WRITE_BYTE, 24'hFFFFFF, 8'hFF, 1'b0);
    send_command(CMD_POWER_DOWN, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_WRITE_BYTE, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_READ_STATUS, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_POLL_REPLY, 24'h000000, 8'hFF, 1'b0);
    send_command(CMD_POLL_REPLY, 24'h000000, 8'hFE, 1'b0);
    send_command(CMD_WRITE_BYTE, 24'h000000, 8'hA5, 1'b1);
    send_command(CMD_POLL_REPLY, 24'hFFFFFF, 8'h00, 1'b1);
    send_command(CMD_WRITE_START, 24'hFFFFFF, 8'h00, 1'b0);
    send_command(CMD_WRITE_BYTE, 24'h000000, 8'h3C, 1'b0);
    send_command(CMD_POLL_REPLY, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_WRITE_BYTE, 24'h000000, 8'hC3, 1'b1);
    send_command(CMD_POLL_REPLY, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_ERASE_4K, 24'h000000, 8'h00, 1'b0);
    send_command(CMD_POLL_REPLY, 24'h000000, 8'h00, 1'b0);

    start_items = items_sent;
    for (int p = 0; p < 5; p++) begin
      wait_all_words();
      m = (p == 3) ? 8'($urandom) : mask_plan[p];
      cfg_write_enable <= 1'b1;
      cfg_write_data <= m;
      @(posedge clk);
      cfg_write_enable <= 1'b0;
      board.busy_mask = m;
      idle_on = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
      while (items_sent - start_items < (p + 1) * 30) begin
        r = $urandom_range(0, 99);
        a = 24'($urandom);
        if (r < 30) begin
          if ($urandom_range(0, 1))
            a = 24'(a - (a % PAGE_BYTES) + PAGE_BYTES - $urandom_range(1, 16));
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
          send_command(CMD_WRITE_START, a, 8'($urandom), 1'($urandom));
          for (int i = 0; i < len; i++) begin
            send_command(CMD_WRITE_BYTE, 24'($urandom), 8'($urandom), i == len - 1);
            if (board.phase == PH_POLL_RESUME || board.phase == PH_POLL_END)
              answer_polls();
          end
        end else if (r < 45) begin
          len = $urandom_range(1, 6);
          send_command(CMD_READ_START, a, 8'($urandom), 1'($urandom));
          for (int i = 0; i < len; i++)
            send_command(CMD_READ_BYTE, 24'($urandom), 8'($urandom), i == len - 1);
        end else if (r < 55) begin
          send_command(CMD_ERASE_4K, a, 8'($urandom), 1'($urandom));
          answer_polls();
        end else if (r < 62) begin
          send_command(CMD_SET_STATUS, a, 8'($urandom), 1'($urandom));
        end else if (r < 70) begin
          send_command(CMD_READ_STATUS, a, 8'($urandom), 1'($urandom));
        end else if (r < 75) begin
          send_command(CMD_POWER_DOWN, a, 8'($urandom), 1'($urandom));
        end else if (r < 80) begin
          wait_all_words();
        end else begin
          repeat ($urandom_range(1, 3))
            send_command(4'($urandom), 24'($urandom), 8'($urandom), 1'($urandom));
          recover_idle();
        end
      end
    end

    recover_idle();
    wait_all_words();
    repeat (32) @(posedge clk);
    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sfcs_pkg.sv
rtl/core/sfcs_front.sv
rtl/core/sfcs_queue.sv
rtl/core/sfcs_back.sv
rtl/core/spi_flash_command_sequencer_core.sv
sim/tb.sv
